// File: design/kli_pkg.sv
// Shared constants, status codes and types of the keyframe interpolator.
package kli_pkg;
  localparam int MaxFrames = 8;
  localparam int IdxW      = $clog2(MaxFrames);
  localparam int CntW      = $clog2(MaxFrames + 1);
  localparam int NChan     = 8;
  localparam logic [15:0] TimeOne = 16'd32768;

  typedef enum logic [2:0] {
    StOk     = 3'd0,
    StStored = 3'd1,
    StRange  = 3'd2,
    StEmpty  = 3'd3,
    StFull   = 3'd4,
    StOrder  = 3'd5
  } status_e;

  typedef logic signed [15:0] chan_t;
  typedef chan_t [NChan-1:0] chans_t;

  // Word handed from one cell to the next.
  typedef struct packed {
    logic [15:0] t;
    chans_t      ch;
    logic        vld;
  } frame_t;
endpackage

// File: design/kli_cell.sv
// One keyframe cell: holds a frame, loads the frame on prev_i when shift_i is set.
module kli_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  kli_pkg::frame_t prev_i,
  output kli_pkg::frame_t frame_o
);
  import kli_pkg::*;
  logic        vld_q;
  logic [15:0] t_q;
  chans_t      ch_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= prev_i.vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      t_q  <= prev_i.t;
      ch_q <= prev_i.ch;
    end
  end
  assign frame_o.t   = t_q;
  assign frame_o.ch  = ch_q;
  assign frame_o.vld = vld_q;
endmodule

// File: design/kli_div.sv
// Restoring divider: floor(num * 2^15 / den), one quotient bit per cycle.
module kli_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [14:0] quo_o
);
  import kli_pkg::*;
  logic [16:0] rem_q, rem_d;
  logic [15:0] den_q;
  logic [14:0] quo_q;
  logic [3:0]  cnt_q;
  logic        busy_q;
  logic [17:0] sh;
  always_comb begin
    sh = {rem_q, 1'b0};
    rem_d = sh[16:0];
    if (sh >= {2'b0, den_q}) rem_d = 17'(sh - {2'b0, den_q});
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd0;
      end else if (busy_q) begin
        cnt_q <= 4'(cnt_q + 4'd1);
        if (cnt_q == 4'd14) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[13:0], (sh >= {2'b0, den_q})};
    end
  end
  assign quo_o = quo_q;
endmodule

// File: design/keyframe_linear_interpolator_core.sv
// Keyframe linear interpolator: a chain of keyframe cells plus a shared divider.
// The keyframe table is a row of MaxFrames cells. A load checks the time, a
// full table and order against the last stored frame, then writes the frame
// into the first free cell. A query rotates the ring of cells one step per
// cycle so each frame passes cell zero, where the bracketing pair is
// captured; then the divider makes the 15-bit fraction in 15 steps, and the
// eight channel products are formed through a single 17x16 multiplier, one
// channel at a time (multiply, then add). A load or an error goes straight
// to the output state, a held-end query goes there after the scan, and an
// interior query after the scan, divider launch, divide steps, fraction
// capture and multiply/add steps; valid_o is set from the output state.
// The result sits in an output register and is held under stall_i; a new
// word is taken only once it is gone, in the cycle after the result leaves.
module keyframe_linear_interpolator_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic                 mode_i,
  input  logic [15:0]          time_req_i,
  input  logic signed [15:0]   in_red_i,
  input  logic signed [15:0]   in_green_i,
  input  logic signed [15:0]   in_blue_i,
  input  logic signed [15:0]   in_alpha_i,
  input  logic signed [15:0]   in_scale_x_i,
  input  logic signed [15:0]   in_scale_y_i,
  input  logic signed [15:0]   in_scale_z_i,
  input  logic signed [15:0]   in_pressure_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic [2:0]           status_o,
  output logic signed [15:0]   out_red_o,
  output logic signed [15:0]   out_green_o,
  output logic signed [15:0]   out_blue_o,
  output logic signed [15:0]   out_alpha_o,
  output logic signed [15:0]   out_scale_x_o,
  output logic signed [15:0]   out_scale_y_o,
  output logic signed [15:0]   out_scale_z_o,
  output logic signed [15:0]   out_pressure_o
);
  import kli_pkg::*;

  typedef enum logic [5:0] {
    SIdle = 6'b000001,
    SScan = 6'b000010,
    SDiv  = 6'b000100,
    SMul  = 6'b001000,
    SAdd  = 6'b010000,
    SOut  = 6'b100000
  } state_e;

  state_e state_q;

  // Cell chain. In load mode cell at count takes the new frame; in scan mode
  // the chain rotates: cell i takes cell i+1, the last takes cell 0.
  frame_t cell_q [MaxFrames];
  frame_t cell_in [MaxFrames];
  logic   cell_sh [MaxFrames];
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] scan_q;
  logic   load_now, rotate;
  frame_t new_frame;

  assign new_frame.t   = time_req_i;
  assign new_frame.ch  = {in_pressure_i, in_scale_z_i, in_scale_y_i, in_scale_x_i,
                          in_alpha_i, in_blue_i, in_green_i, in_red_i};
  assign new_frame.vld = 1'b1;

  for (genvar g = 0; g < MaxFrames; g++) begin : g_cells
    always_comb begin
      cell_in[g] = rotate ? cell_q[(g + 1) % MaxFrames] : new_frame;
      cell_sh[g] = rotate || (load_now && cnt_q == CntW'(g));
    end
    kli_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(cell_sh[g]),
      .prev_i (cell_in[g]),
      .frame_o(cell_q[g])
    );
  end

  // Last stored time, tracked alongside the table.
  logic [15:0] last_t_q;
  logic [15:0] t_q;
  logic        acc;
  assign stall_o = (state_q != SIdle) || valid_o;
  assign acc     = valid_i && !stall_o;

  // Load-time checks.
  status_e ld_st;
  always_comb begin
    priority if (time_req_i > TimeOne)           ld_st = StRange;
    else if (cnt_q >= CntW'(MaxFrames))          ld_st = StFull;
    else if (cnt_q != '0 && time_req_i < last_t_q) ld_st = StOrder;
    else                                          ld_st = StStored;
  end
  assign load_now = acc && !mode_i && ld_st == StStored;
  assign rotate   = state_q == SScan;

  // Scan captures: first frame, last frame, bracketing pair (first t2 > t).
  logic [15:0] t1_q, t2_q;
  chans_t      v1_q, v2_q, first_ch_q;
  logic [15:0] first_t_q;
  logic        found_q;
  frame_t      prev_q;
  logic [15:0] span;
  logic [15:0] off;
  logic        dv_start, dv_done;
  logic [14:0] frac;

  assign span = 16'(t2_q - t1_q);
  assign off  = 16'(t_q - t1_q);

  kli_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dv_start),
    .num_i  (off),
    .den_i  (span),
    .done_o (dv_done),
    .quo_o  (frac)
  );

  // Channel multiply, one channel at a time: a multiply step, then an add step.
  logic [2:0]         ch_q;
  logic [14:0]        frac_q;
  logic signed [16:0] diff;
  logic signed [32:0] prod_q;
  logic signed [15:0] v1_sel;
  chans_t             res_q;
  chans_t             res_d;
  assign diff = 17'($signed(v2_q[ch_q])) - 17'($signed(v1_q[ch_q]));

  // Current channel replaced by v1 + floor(diff * frac / 2^15).
  always_comb begin
    res_d = res_q;
    res_d[ch_q] = 16'(v1_sel + 16'(prod_q >>> 15));
  end

  status_e out_st_q;
  chans_t  out_ch_q;

  logic is_last;
  assign is_last = scan_q == CntW'(cnt_q - CntW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      cnt_q    <= '0;
      valid_o  <= 1'b0;
      dv_start <= 1'b0;
    end else begin
      dv_start <= 1'b0;
      if (valid_o && !stall_i) valid_o <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (acc) begin
            if (time_req_i > TimeOne) begin
              out_st_q <= StRange;
              state_q  <= SOut;
            end else if (!mode_i) begin
              out_st_q <= ld_st;
              if (ld_st == StStored) cnt_q <= CntW'(cnt_q + CntW'(1));
              state_q <= SOut;
            end else if (cnt_q == '0) begin
              out_st_q <= StEmpty;
              state_q  <= SOut;
            end else begin
              state_q <= SScan;
            end
          end
        end
        SScan: begin
          // Full ring rotation restores the original order after MaxFrames steps.
          if (scan_q == CntW'(MaxFrames - 1)) begin
            out_st_q <= StOk;
            if (t_q >= last_t_q) begin
              // A full table has its last frame in cell zero right now.
              out_ch_q <= is_last ? cell_q[0].ch : res_q;
              state_q  <= SOut;
            end else if (t_q <= first_t_q) begin
              out_ch_q <= first_ch_q;
              state_q  <= SOut;
            end else begin
              dv_start <= 1'b1;
              state_q  <= SDiv;
            end
          end
        end
        SDiv: if (dv_done) state_q <= SMul;
        SMul: state_q <= SAdd;
        SAdd: begin
          if (ch_q == 3'(NChan - 1)) begin
            out_ch_q <= res_d;
            state_q  <= SOut;
          end else begin
            state_q <= SMul;
          end
        end
        SOut: begin
          valid_o <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign v1_sel = v1_q[ch_q];

  always_ff @(posedge clk_i) begin
    if (acc) begin
      t_q    <= time_req_i;
      scan_q <= '0;
      found_q <= 1'b0;
      ch_q   <= '0;
      if (load_now) last_t_q <= time_req_i;
    end
    if (state_q == SScan) begin
      scan_q <= CntW'(scan_q + CntW'(1));
      prev_q <= cell_q[0];
      if (scan_q == '0) begin
        first_t_q  <= cell_q[0].t;
        first_ch_q <= cell_q[0].ch;
      end
      if (is_last) res_q <= cell_q[0].ch;
      if (scan_q != '0 && scan_q < cnt_q && !found_q && t_q < cell_q[0].t) begin
        found_q <= 1'b1;
        t1_q <= prev_q.t;
        v1_q <= prev_q.ch;
        t2_q <= cell_q[0].t;
        v2_q <= cell_q[0].ch;
      end
    end
    if (dv_done) frac_q <= frac;
    if (state_q == SMul) prod_q <= diff * $signed({1'b0, frac_q});
    if (state_q == SAdd) begin
      res_q <= res_d;
      ch_q  <= 3'(ch_q + 3'd1);
    end
  end

  assign status_o       = (valid_o) ? out_st_q : out_st_q;
  assign out_red_o      = out_st_q == StOk ? out_ch_q[0] : '0;
  assign out_green_o    = out_st_q == StOk ? out_ch_q[1] : '0;
  assign out_blue_o     = out_st_q == StOk ? out_ch_q[2] : '0;
  assign out_alpha_o    = out_st_q == StOk ? out_ch_q[3] : '0;
  assign out_scale_x_o  = out_st_q == StOk ? out_ch_q[4] : '0;
  assign out_scale_y_o  = out_st_q == StOk ? out_ch_q[5] : '0;
  assign out_scale_z_o  = out_st_q == StOk ? out_ch_q[6] : '0;
  assign out_pressure_o = out_st_q == StOk ? out_ch_q[7] : '0;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> !acc) else $error("word taken while busy");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxFrames)) else $error("frame count overflow");
  a_out_from_sout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> $past(state_q) == SOut) else $error("result without finish");
endmodule
